// ===== design/load_cell_serial_reader_top_macros.svh =====
// Assertion macros for the load cell serial reader; lcsr_back uses them.
// Expects aclk and aresetn to be visible where a macro is used.
`ifndef LOAD_CELL_SERIAL_READER_TOP_MACROS_SVH
`define LOAD_CELL_SERIAL_READER_TOP_MACROS_SVH

// Property that holds in the same cycle.
`define LCSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define LCSR_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lcsr_pkg.sv =====
// Shared types, constants and register map for the load cell serial reader.
// No dependencies.
package lcsr_pkg;

    localparam int RAW_BITS_DEF        = 24;
    localparam int SCALE_FRAC_BITS_DEF = 8;

    localparam int OFFSET_W = 24;
    localparam int SCALE_W  = 24;
    localparam int WEIGHT_W = 32;
    localparam int QUO_W    = WEIGHT_W - 1;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int QUEUE_DEPTH = 2;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;
    localparam logic [1:0] REG_GLITCH = 2'd3;

    localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd256;
    localparam logic [WEIGHT_W-1:0] GLITCH_RST = 32'd342;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic pulse;
        logic done;
        logic busy;
    } slot_flags_t;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic             sat;
        logic             zero;
        logic [QUO_W-1:0] q;
    } div_res_t;

endpackage

// ===== design/load_cell_serial_reader_top.sv =====
// Order: a plain slot is written into the queue, then popped into the result register
// once the output is free; a completion slot waits for the one-bit-per-cycle divider
// (31 steps), whose steps are skipped when the weight saturates or the difference is zero.
// Throughput: one slot per cycle while the two-entry queue has room; a completion slot
// holds the back end until its weight is loaded. Reset is synchronous and active low; it
// clears the sequencer, queue and output, restores register defaults, and needs no clearing pass.
module load_cell_serial_reader_top #(
    parameter int RAW_BITS        = lcsr_pkg::RAW_BITS_DEF,
    parameter int SCALE_FRAC_BITS = lcsr_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lcsr_pkg::ADDR_W-1:0]          paddr,
    input  logic [lcsr_pkg::DATA_W-1:0]          pwdata,
    output logic [lcsr_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_dout_level,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_clock_pulse,
    output logic                                 m_new_weight,
    output logic signed [lcsr_pkg::WEIGHT_W-1:0] m_weight,
    output logic                                 m_busy_res
);

    localparam int OFFSET_W = lcsr_pkg::OFFSET_W;
    localparam int SCALE_W  = lcsr_pkg::SCALE_W;
    localparam int WEIGHT_W = lcsr_pkg::WEIGHT_W;
    localparam int FLAGS_W  = $bits(lcsr_pkg::slot_flags_t);
    localparam int ENTRY_W  = FLAGS_W + RAW_BITS;

    logic                       enable_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [SCALE_W-1:0]         scale_reg;
    logic signed [WEIGHT_W-1:0] glitch_reg;
    logic                       cfg_write;
    logic [1:0]                 reg_index;

    logic                  push;
    lcsr_pkg::slot_flags_t push_flags;
    logic [RAW_BITS-1:0]   push_raw;
    logic                  pop;
    logic                  queue_empty;
    logic                  queue_full;
    logic [ENTRY_W-1:0]    head_data;
    lcsr_pkg::slot_flags_t head_flags;
    logic [RAW_BITS-1:0]   head_raw;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            offset_reg <= lcsr_pkg::OFFSET_RST;
            scale_reg  <= lcsr_pkg::SCALE_RST;
            glitch_reg <= lcsr_pkg::GLITCH_RST;
        end else if (cfg_write) begin
            case (reg_index)
                lcsr_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                lcsr_pkg::REG_OFFSET: offset_reg <= pwdata[OFFSET_W-1:0];
                lcsr_pkg::REG_SCALE:  scale_reg  <= pwdata[SCALE_W-1:0];
                lcsr_pkg::REG_GLITCH: glitch_reg <= pwdata[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            lcsr_pkg::REG_ENABLE: prdata = {{(lcsr_pkg::DATA_W-1){1'b0}}, enable_reg};
            lcsr_pkg::REG_OFFSET: prdata = lcsr_pkg::DATA_W'($unsigned(offset_reg));
            lcsr_pkg::REG_SCALE:  prdata = lcsr_pkg::DATA_W'(scale_reg);
            lcsr_pkg::REG_GLITCH: prdata = glitch_reg;
            default:              prdata = '0;
        endcase
    end

    lcsr_front #(
        .RAW_BITS (RAW_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .enable       (enable_reg),
        .s_valid      (s_valid),
        .s_dout_level (s_dout_level),
        .s_ready      (s_ready),
        .queue_full   (queue_full),
        .push         (push),
        .push_flags   (push_flags),
        .push_raw     (push_raw)
    );

    lcsr_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (lcsr_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_flags, push_raw}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    assign head_flags = head_data[ENTRY_W-1 -: FLAGS_W];
    assign head_raw   = head_data[RAW_BITS-1:0];

    lcsr_back #(
        .RAW_BITS        (RAW_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .queue_empty   (queue_empty),
        .head_flags    (head_flags),
        .head_raw      (head_raw),
        .pop           (pop),
        .offset        (offset_reg),
        .scale         (scale_reg),
        .glitch_value  (glitch_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_clock_pulse (m_clock_pulse),
        .m_new_weight  (m_new_weight),
        .m_weight      (m_weight),
        .m_busy_res    (m_busy_res)
    );

endmodule

// ===== design/lcsr_front.sv =====
// Front end: takes pulse slots, runs the read sequence and classifies each slot.
// Depends on lcsr_pkg.
module lcsr_front #(
    parameter int RAW_BITS = lcsr_pkg::RAW_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 enable,
    input  logic                 s_valid,
    input  logic                 s_dout_level,
    output logic                 s_ready,
    input  logic                 queue_full,
    output logic                 push,
    output lcsr_pkg::slot_flags_t push_flags,
    output logic [RAW_BITS-1:0]  push_raw
);

    localparam int DONE_PHASE = RAW_BITS + 1;
    localparam int PHASE_W    = $clog2(DONE_PHASE + 1);

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                last_dout_reg;
    logic [RAW_BITS-1:0] shift_reg, shift_next;

    assign s_ready  = !queue_full;
    assign push     = s_valid && s_ready;
    assign push_raw = shift_reg;

    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        push_flags = '0;
        if (phase_reg == '0) begin
            if (enable && last_dout_reg && !s_dout_level) begin
                phase_next = PHASE_W'(1);
            end
        end else if (phase_reg <= PHASE_W'(RAW_BITS)) begin
            push_flags.pulse = 1'b1;
            shift_next = {shift_reg[RAW_BITS-2:0], s_dout_level};
            phase_next = phase_reg + PHASE_W'(1);
        end else begin
            // Extra pulse: the word is complete and goes to the divider.
            push_flags.pulse = 1'b1;
            push_flags.done  = 1'b1;
            phase_next = '0;
        end
        push_flags.busy = (phase_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            last_dout_reg <= 1'b1;
            shift_reg     <= '0;
        end else if (push) begin
            phase_reg     <= phase_next;
            last_dout_reg <= s_dout_level;
            shift_reg     <= shift_next;
        end
    end

endmodule

// ===== design/lcsr_fifo.sv =====
// Short register queue between the front end and the back end.
// Depends on nothing but its parameters.
module lcsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/lcsr_div.sv =====
// Sequential weight divider: offset subtraction, then restoring division one
// quotient bit per cycle with an up-front saturation check. Depends on lcsr_pkg.
module lcsr_div #(
    parameter int RAW_BITS        = lcsr_pkg::RAW_BITS_DEF,
    parameter int SCALE_FRAC_BITS = lcsr_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [RAW_BITS-1:0]                  raw,
    input  logic signed [lcsr_pkg::OFFSET_W-1:0] offset,
    input  logic [lcsr_pkg::SCALE_W-1:0]         scale,
    output lcsr_pkg::div_res_t                   res
);

    localparam int SCALE_W = lcsr_pkg::SCALE_W;
    localparam int QUO_W   = lcsr_pkg::QUO_W;
    localparam int DIFF_W  = ((RAW_BITS > lcsr_pkg::OFFSET_W) ? RAW_BITS
                                                              : lcsr_pkg::OFFSET_W) + 1;
    localparam int DVD_W   = DIFF_W + SCALE_FRAC_BITS;
    localparam int LIM_W   = SCALE_W + QUO_W;
    localparam int CMP_W   = (DVD_W > LIM_W) ? DVD_W : LIM_W;
    localparam int CNT_W   = $clog2(QUO_W);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_PREP = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    logic [1:0]               stage_reg, stage_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [SCALE_W-1:0]       rem_reg, rem_next;
    logic [QUO_W-1:0]         low_reg, low_next;
    logic [QUO_W-1:0]         q_reg, q_next;
    logic                     neg_reg, sat_reg, zero_reg;

    logic [DIFF_W-1:0]  mag;
    logic [CMP_W-1:0]   dvd;
    logic [CMP_W-1:0]   lim;
    logic [SCALE_W:0]   trial;
    logic               trial_ge;

    assign mag   = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign dvd   = CMP_W'(mag) << SCALE_FRAC_BITS;
    assign lim   = CMP_W'(scale) << QUO_W;
    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign trial_ge = (trial >= {1'b0, scale});

    always_comb begin
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        case (stage_reg)
            D_IDLE: begin
                if (start) begin
                    stage_next = D_PREP;
                end
            end
            D_PREP: begin
                // Quotient needs 31 bits or fewer once the saturation check fails,
                // so the upper dividend bits already sit below the divisor.
                rem_next = dvd[QUO_W +: SCALE_W];
                low_next = dvd[QUO_W-1:0];
                q_next   = '0;
                cnt_next = CNT_W'(QUO_W - 1);
                stage_next = ((dvd >= lim) || (mag == '0)) ? D_IDLE : D_RUN;
            end
            D_RUN: begin
                rem_next = trial_ge ? SCALE_W'(trial - {1'b0, scale}) : trial[SCALE_W-1:0];
                low_next = {low_reg[QUO_W-2:0], 1'b0};
                q_next   = {q_reg[QUO_W-2:0], trial_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    stage_next = D_IDLE;
                end
            end
            default: begin
                stage_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= D_IDLE;
        end else begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        if (stage_reg == D_IDLE && start) begin
            diff_reg <= DIFF_W'($signed(raw)) - DIFF_W'(offset);
        end
        if (stage_reg == D_PREP) begin
            neg_reg  <= diff_reg[DIFF_W-1];
            sat_reg  <= (dvd >= lim);
            zero_reg <= (mag == '0);
        end
    end

    assign res.done = (stage_reg == D_IDLE);
    assign res.neg  = neg_reg;
    assign res.sat  = sat_reg;
    assign res.zero = zero_reg;
    assign res.q    = q_reg;

endmodule

// ===== design/lcsr_back.sv =====
// Back end: drains the slot queue, runs the divider for completed reads and
// drives the registered result channel. Depends on lcsr_pkg, lcsr_div and the assertion macros.
`include "load_cell_serial_reader_top_macros.svh"

module lcsr_back #(
    parameter int RAW_BITS        = lcsr_pkg::RAW_BITS_DEF,
    parameter int SCALE_FRAC_BITS = lcsr_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 queue_empty,
    input  lcsr_pkg::slot_flags_t                head_flags,
    input  logic [RAW_BITS-1:0]                  head_raw,
    output logic                                 pop,
    input  logic signed [lcsr_pkg::OFFSET_W-1:0] offset,
    input  logic [lcsr_pkg::SCALE_W-1:0]         scale,
    input  logic signed [lcsr_pkg::WEIGHT_W-1:0] glitch_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_clock_pulse,
    output logic                                 m_new_weight,
    output logic signed [lcsr_pkg::WEIGHT_W-1:0] m_weight,
    output logic                                 m_busy_res
);

    localparam int WEIGHT_W = lcsr_pkg::WEIGHT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                  state_reg, state_next;
    logic                  m_valid_reg;
    lcsr_pkg::slot_flags_t out_flags_reg, out_flags;
    logic [WEIGHT_W-1:0]   held_reg, held_next;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [WEIGHT_W-1:0]   calc_w;
    logic [WEIGHT_W-1:0]   q_ext;
    logic                  out_free;
    logic                  out_load;
    logic                  div_start;
    lcsr_pkg::div_res_t    div_res;

    lcsr_div #(
        .RAW_BITS        (RAW_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .raw     (head_raw),
        .offset  (offset),
        .scale   (scale),
        .res     (div_res)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign q_ext    = {1'b0, div_res.q};

    always_comb begin
        if (div_res.zero) begin
            calc_w = '0;
        end else if (div_res.sat) begin
            calc_w = div_res.neg ? lcsr_pkg::WEIGHT_MIN : lcsr_pkg::WEIGHT_MAX;
        end else begin
            calc_w = div_res.neg ? ('0 - q_ext) : q_ext;
        end
    end

    always_comb begin
        state_next = state_reg;
        held_next  = held_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        out_flags  = head_flags;
        case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    if (head_flags.done) begin
                        pop        = 1'b1;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else if (out_free) begin
                        pop      = 1'b1;
                        out_load = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done && out_free) begin
                    out_load        = 1'b1;
                    out_flags.pulse = 1'b1;
                    out_flags.done  = 1'b1;
                    out_flags.busy  = 1'b0;
                    // A weight equal to the glitch value is dropped.
                    if (calc_w != glitch_value) begin
                        held_next = calc_w;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            held_reg    <= '0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_flags_reg <= out_flags;
            weight_reg    <= held_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_clock_pulse = out_flags_reg.pulse;
    assign m_new_weight  = out_flags_reg.done;
    assign m_busy_res    = out_flags_reg.busy;
    assign m_weight      = weight_reg;

    `LCSR_ASSERT(a_no_overwrite, out_load |-> (!m_valid_reg || m_ready), "beat overwritten")
    `LCSR_ASSERT(a_pop_nonempty, pop |-> !queue_empty, "pop from an empty slot queue")
    `LCSR_ASSERT(a_div_wait, (state_reg == ST_DIV && !div_res.done) |-> !out_load, "early weight")
    `LCSR_ASSERT_NEXT(a_div_started, div_start, !div_res.done, "divider did not start")

endmodule
